// ===== src/gdd_pkg.sv =====
package gdd_pkg;

  localparam int YearW = 14;
  localparam int MonW  = 4;
  localparam int DayW  = 5;
  localparam int NumW  = 22;
  localparam int DiffW = 22;

  localparam int QW    = 8;   // year / 100 for years up to 16383
  localparam int RemW  = 7;
  localparam int OffW  = 9;   // day of year, 0..365
  localparam int C4W   = 13;
  localparam int C400W = 7;

  localparam int YearMax    = 9999;
  localparam int DaysInYear = 365;
  localparam int Div100Mul  = 5243;  // floor(y * 5243 / 2^19) == y / 100 for y < 43690
  localparam int Div100Sh   = 19;
  localparam int ProdW      = YearW + 13;

  localparam logic [MonW-1:0] MonJan = 4'd1;
  localparam logic [MonW-1:0] MonFeb = 4'd2;
  localparam logic [MonW-1:0] MonDec = 4'd12;

  // pipeline stages: three day-number stages and the output stage
  localparam int NumStages = 4;

  typedef logic [YearW-1:0] year_t;
  typedef logic [MonW-1:0]  month_t;
  typedef logic [DayW-1:0]  day_t;
  typedef logic [NumW-1:0]  daynum_t;
  typedef logic [DiffW-1:0] diff_t;

  typedef struct packed {
    logic [NumStages-1:0] load;
  } gdd_adv_t;

  function automatic logic [DayW-1:0] month_len(input month_t m);
    logic [DayW-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [OffW-1:0] days_before(input month_t m);
    logic [OffW-1:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== src/gdd_if.sv =====
interface gdd_in_if;
  logic                 valid;
  logic                 ready;
  gdd_pkg::year_t       first_year;
  gdd_pkg::month_t      first_month;
  gdd_pkg::day_t        first_day;
  gdd_pkg::year_t       second_year;
  gdd_pkg::month_t      second_month;
  gdd_pkg::day_t        second_day;

  modport source (output valid, first_year, first_month, first_day,
                  second_year, second_month, second_day, input ready);
  modport sink   (input valid, first_year, first_month, first_day,
                  second_year, second_month, second_day, output ready);
endinterface

interface gdd_out_if;
  logic                 valid;
  logic                 ready;
  gdd_pkg::diff_t       day_difference;
  logic                 date_invalid;

  modport source (output valid, day_difference, date_invalid, input ready);
  modport sink   (input valid, day_difference, date_invalid, output ready);
endinterface

// ===== src/gdd_pipe_ctrl.sv =====
module gdd_pipe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output gdd_pkg::gdd_adv_t adv
);
  import gdd_pkg::*;

  logic [NumStages-1:0] v_r;
  logic [NumStages-1:0] v_nxt;
  logic [NumStages-1:0] rdy;

  always_comb begin
    rdy[NumStages-1] = !v_r[NumStages-1] || out_ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < NumStages; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign adv.load  = rdy;
  assign in_ready  = rdy[0];
  assign out_valid = v_r[NumStages-1];

  logic in_acc;
  logic out_acc;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(v_r) == $past($countones(v_r))
                      + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("pipeline occupancy does not match requests in and out");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ((&v_r) && !out_ready) |-> !in_ready)
    else $error("request taken while pipeline full and stalled");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("stalled result dropped");

endmodule

// ===== src/gdd_day_num.sv =====
module gdd_day_num (
  input  logic              clk,
  input  gdd_pkg::gdd_adv_t adv,
  input  gdd_pkg::year_t    in_year,
  input  gdd_pkg::month_t   in_month,
  input  gdd_pkg::day_t     in_day,
  output gdd_pkg::daynum_t  num,
  output logic              ok
);
  import gdd_pkg::*;

  // stage 1: year / 100 by reciprocal, range checks
  logic [ProdW-1:0] prod;
  year_t            y1_r;
  month_t           m1_r;
  day_t             d1_r;
  logic [QW-1:0]    q1_r;
  logic             yok1_r;
  logic             mok1_r;

  assign prod = ProdW'(in_year) * ProdW'(Div100Mul);

  always_ff @(posedge clk) begin
    if (adv.load[0]) begin
      y1_r   <= in_year;
      m1_r   <= in_month;
      d1_r   <= in_day;
      q1_r   <= prod[Div100Sh +: QW];
      yok1_r <= in_year <= YearW'(YearMax);
      mok1_r <= (in_month >= MonJan) && (in_month <= MonDec);
    end
  end

  // stage 2: leap year, day check, per-year terms
  logic [RemW-1:0]  r100;
  logic             leap;
  logic [DayW-1:0]  len;
  logic [QW-1:0]    c100;
  logic [QW:0]      c400_sum;
  logic [YearW:0]   c4_sum;
  logic [YearW+8:0] y365;
  logic [OffW-1:0]  off;

  assign r100     = RemW'(y1_r - YearW'(q1_r) * YearW'(100));
  assign leap     = (r100 != '0) ? (y1_r[1:0] == 2'b00) : (q1_r[1:0] == 2'b00);
  assign len      = month_len(m1_r) + DayW'((m1_r == MonFeb) && leap);
  assign c100     = q1_r + QW'(r100 != '0);
  assign c400_sum = {1'b0, c100} + (QW+1)'(3);
  assign c4_sum   = {1'b0, y1_r} + (YearW+1)'(3);
  assign y365     = (YearW+9)'(y1_r) * (YearW+9)'(DaysInYear);
  assign off      = days_before(m1_r) + OffW'((m1_r > MonFeb) && leap)
                    + OffW'(d1_r) - OffW'(1);

  daynum_t          y365_r;
  logic [C4W-1:0]   c4_r;
  logic [QW-1:0]    c100_r;
  logic [C400W-1:0] c400_r;
  logic [OffW-1:0]  off_r;
  logic             ok2_r;

  always_ff @(posedge clk) begin
    if (adv.load[1]) begin
      y365_r <= y365[NumW-1:0];
      c4_r   <= c4_sum[2 +: C4W];
      c100_r <= c100;
      c400_r <= c400_sum[2 +: C400W];
      off_r  <= off;
      ok2_r  <= yok1_r && mok1_r && (d1_r != '0) && (d1_r <= len);
    end
  end

  // stage 3: day number
  daynum_t num_r;
  logic    ok3_r;

  always_ff @(posedge clk) begin
    if (adv.load[2]) begin
      num_r <= y365_r + NumW'(c4_r) - NumW'(c100_r) + NumW'(c400_r) + NumW'(off_r);
      ok3_r <= ok2_r;
    end
  end

  assign num = num_r;
  assign ok  = ok3_r;

endmodule

// ===== src/gregorian_date_difference.sv =====
// Gregorian date difference.
// Input channel in_chan carries a request of two dates (year, month, day);
// output channel out_chan returns |daynum(first) - daynum(second)| in
// day_difference, with day 0 = 0000-01-01. A month outside 1..12, a day of
// 0 or past the month's length, or a year above 9999 in either date sets
// date_invalid and forces day_difference to 0.
// Both channels use valid/ready; a transfer happens when both are high.
// A request taken by in_chan passes through the three day-number stages and
// the output register, the first loaded by the edge that takes it. The
// pipeline takes one request per cycle while out_chan does not stall; the
// year/100 reciprocal multiply, the 365*year multiply and the day-number sum
// each take one stage.
// When out_chan stalls, results are held and in_ready stays high until
// every stage holds an item, so empty stages still fill.
// Reset (rst_n low, synchronous) empties the pipeline; no result is
// presented until new requests arrive.
module gregorian_date_difference (
  input  logic clk,
  input  logic rst_n,
  gdd_in_if.sink    in_chan,
  gdd_out_if.source out_chan
);
  import gdd_pkg::*;

  gdd_adv_t adv;
  daynum_t  num_a;
  daynum_t  num_b;
  logic     ok_a;
  logic     ok_b;

  gdd_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .adv       (adv)
  );

  gdd_day_num u_num_a (
    .clk      (clk),
    .adv      (adv),
    .in_year  (in_chan.first_year),
    .in_month (in_chan.first_month),
    .in_day   (in_chan.first_day),
    .num      (num_a),
    .ok       (ok_a)
  );

  gdd_day_num u_num_b (
    .clk      (clk),
    .adv      (adv),
    .in_year  (in_chan.second_year),
    .in_month (in_chan.second_month),
    .in_day   (in_chan.second_day),
    .num      (num_b),
    .ok       (ok_b)
  );

  diff_t diff;
  logic  both_ok;
  diff_t diff_r;
  logic  inv_r;

  assign both_ok = ok_a && ok_b;
  assign diff    = !both_ok ? '0 :
                   (num_a >= num_b) ? DiffW'(num_a - num_b) : DiffW'(num_b - num_a);

  always_ff @(posedge clk) begin
    if (adv.load[NumStages-1]) begin
      diff_r <= diff;
      inv_r  <= !both_ok;
    end
  end

  assign out_chan.day_difference = diff_r;
  assign out_chan.date_invalid   = inv_r;

  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.date_invalid) |-> (out_chan.day_difference == '0))
    else $error("invalid date with nonzero difference");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |=> ($stable(diff_r) && $stable(inv_r)))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.day_difference <= DiffW'(3652424)))
    else $error("difference out of range");

endmodule
